// File: rtl/packet_frame_reassembler_crc_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packet frame reassembler
// Shorthand for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_FRAME_REASSEMBLER_CRC_MACROS_SVH
`define PACKET_FRAME_REASSEMBLER_CRC_MACROS_SVH

// same-cycle implication
`define PFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfr assertion failed");

// next-cycle implication
`define PFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfr assertion failed");

`endif

// File: rtl/pfr_pkg.sv
// ----------------------------------------------------------------------------
// Packet frame reassembler package
// Sizes, item kinds, status codes and the M17 CRC-16 byte step.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = 11;
    localparam int PLEN_W      = 10;
    localparam int POS_W       = 5;

    localparam logic [POS_W-1:0] POS_MAX = 5'd31;
    localparam logic [15:0]      CRC_POLY = 16'h5935;
    localparam logic [15:0]      CRC_INIT = 16'hFFFF;

    // item kinds (tuser)
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_CLEAR   = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // result status codes
    localparam logic [2:0] ST_PROGRESS = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_SEQUENCE = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;
    localparam logic [2:0] ST_CRC      = 3'd5;

    // verdict of an accepted end frame, CRC check still to come
    localparam logic [2:0] VERDICT_END_OK = 3'd1;

    // one byte through the CRC, MSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/pfr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/packet_frame_reassembler_crc.sv
// ----------------------------------------------------------------------------
// Packet frame reassembler with M17 CRC-16 check
// One item per cycle while the result side is not stalled; a taken item's result
// passes through the middle stage (state update, store read) and the output register.
// Synchronous active-low reset clears capacity and reassembly state but the last two bytes.
// ----------------------------------------------------------------------------
`include "packet_frame_reassembler_crc_macros.svh"

module packet_frame_reassembler_crc
    import pfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: capacity
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // data_byte[7:0], frame_counter[12:8],
                                    // frame_eof[13], read_index[23:14]
    input  logic [1:0]  i_s_tuser,  // kind[1:0]
    input  logic        i_s_tlast,  // last_byte
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata   // status[2:0], packet_length[12:3],
                                    // stored_length[23:13], read_data[31:24]
);

    // input fields
    logic [1:0]        in_kind;
    logic [7:0]        in_data;
    logic [4:0]        in_counter;
    logic              in_eof;
    logic              in_last;
    logic [ADDR_W-1:0] in_ridx;

    assign in_kind    = i_s_tuser;
    assign in_data    = i_s_tdata[7:0];
    assign in_counter = i_s_tdata[12:8];
    assign in_eof     = i_s_tdata[13];
    assign in_last    = i_s_tlast;
    assign in_ridx    = i_s_tdata[23:14];

    // reassembly state
    logic [LEN_W-1:0]  r_capacity;
    logic [LEN_W-1:0]  r_total,    n_total;
    logic [PLEN_W-1:0] r_payload,  n_payload;
    logic [7:0]        r_expected, n_expected;
    logic [15:0]       r_crc,      n_crc;
    logic [2:0]        r_verdict,  n_verdict;
    logic [POS_W-1:0]  r_pos,      n_pos;
    logic [POS_W-1:0]  r_take,     n_take;
    logic [7:0]        r_last1,    n_last1;   // newest stored byte
    logic [7:0]        r_last2,    n_last2;   // one before it

    // pipeline
    logic              s_acc;
    logic              adv;
    logic              n_has_result;
    logic [2:0]        n_status;
    logic              do_append;

    logic              r_mid_valid;
    logic              r_mid_read;
    logic [2:0]        r_mid_status;
    logic [PLEN_W-1:0] r_mid_plen;
    logic [LEN_W-1:0]  r_mid_slen;

    logic              r_out_valid;
    logic [31:0]       r_out_data;

    logic [7:0]        ram_rdata;

    // frame start checks
    logic [LEN_W-1:0]  cap_eff;
    logic [LEN_W:0]    sum_full;
    logic [LEN_W:0]    sum_end;
    logic [2:0]        start_verdict;
    logic [POS_W-1:0]  start_take;
    logic [7:0]        start_expected;
    logic [2:0]        cur_verdict;
    logic [POS_W-1:0]  cur_take;

    // assertion helpers
    logic              clr_acc;
    logic              end_acc;
    logic              clr_done;

    assign adv         = !r_out_valid || i_m_tready;
    assign o_s_tready  = adv;
    assign s_acc       = i_s_tvalid && adv;
    assign o_cfg_ready = 1'b1;

    assign cap_eff  = (r_capacity > LEN_W'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH) : r_capacity;
    assign sum_full = {1'b0, r_total} + (LEN_W + 1)'(FRAME_BYTES);
    assign sum_end  = {1'b0, r_total} + {{(LEN_W + 1 - 5){1'b0}}, in_counter};

    always_comb begin
        start_verdict  = ST_PROGRESS;
        start_take     = '0;
        start_expected = r_expected;
        if (cap_eff == '0) begin
            start_verdict = ST_OVERFLOW;
        end else if (!in_eof) begin
            if ({3'b000, in_counter} != r_expected) begin
                start_verdict = ST_SEQUENCE;
            end else if (sum_full > {1'b0, cap_eff}) begin
                start_verdict = ST_OVERFLOW;
            end else begin
                start_verdict  = ST_PROGRESS;
                start_take     = POS_W'(FRAME_BYTES);
                start_expected = r_expected + 8'd1;
            end
        end else begin
            if (in_counter == '0 || in_counter > POS_W'(FRAME_BYTES)) begin
                start_verdict = ST_INVALID;
            end else if (sum_end > {1'b0, cap_eff}) begin
                start_verdict = ST_OVERFLOW;
            end else begin
                start_verdict = VERDICT_END_OK;
                start_take    = in_counter;
            end
        end
    end

    assign cur_verdict = (r_pos == '0) ? start_verdict : r_verdict;
    assign cur_take    = (r_pos == '0) ? start_take    : r_take;
    assign do_append   = (in_kind == KIND_PAYLOAD) && (r_pos < cur_take) &&
                         (r_total < LEN_W'(STORE_DEPTH));

    always_comb begin
        n_total      = r_total;
        n_payload    = r_payload;
        n_expected   = r_expected;
        n_crc        = r_crc;
        n_verdict    = r_verdict;
        n_pos        = r_pos;
        n_take       = r_take;
        n_last1      = r_last1;
        n_last2      = r_last2;
        n_has_result = 1'b0;
        n_status     = ST_PROGRESS;

        case (in_kind)
            KIND_CLEAR: begin
                n_total    = '0;
                n_payload  = '0;
                n_expected = '0;
                n_crc      = CRC_INIT;
                n_verdict  = ST_PROGRESS;
                n_pos      = '0;
                n_take     = '0;
            end
            KIND_READ: begin
                n_has_result = 1'b1;
            end
            KIND_PAYLOAD: begin
                n_verdict  = cur_verdict;
                n_take     = cur_take;
                if (r_pos == '0) begin
                    n_expected = start_expected;
                end
                if (do_append) begin
                    // CRC trails the append point by two bytes
                    if (r_total >= LEN_W'(2)) begin
                        n_crc = crc_fold(r_crc, r_last2);
                    end
                    n_last2 = r_last1;
                    n_last1 = in_data;
                    n_total = r_total + LEN_W'(1);
                end
                if (in_last) begin
                    n_pos        = '0;
                    n_has_result = 1'b1;
                    if (cur_verdict != VERDICT_END_OK) begin
                        n_status = cur_verdict;
                    end else if (n_total < LEN_W'(3) || n_total > LEN_W'(STORE_DEPTH)) begin
                        n_status = ST_CRC;
                    end else if ({n_last2, n_last1} != n_crc) begin
                        n_status = ST_CRC;
                    end else begin
                        n_status  = ST_COMPLETE;
                        n_payload = PLEN_W'(n_total - LEN_W'(2));
                    end
                end else if (r_pos != POS_MAX) begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_payload  <= '0;
            r_expected <= '0;
            r_crc      <= CRC_INIT;
            r_verdict  <= ST_PROGRESS;
            r_pos      <= '0;
            r_take     <= '0;
        end else if (s_acc) begin
            r_total    <= n_total;
            r_payload  <= n_payload;
            r_expected <= n_expected;
            r_crc      <= n_crc;
            r_verdict  <= n_verdict;
            r_pos      <= n_pos;
            r_take     <= n_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_last1 <= n_last1;
            r_last2 <= n_last2;
        end
    end

    pfr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_acc && do_append),
        .i_waddr (r_total[ADDR_W-1:0]),
        .i_wdata (in_data),
        .i_re    (s_acc && in_kind == KIND_READ),
        .i_raddr (in_ridx),
        .o_rdata (ram_rdata)
    );

    // middle stage: result fields while the store read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (adv) begin
            r_mid_valid <= s_acc && n_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mid_read   <= (in_kind == KIND_READ);
            r_mid_status <= n_status;
            r_mid_plen   <= n_payload;
            r_mid_slen   <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {(r_mid_read ? ram_rdata : 8'h00), r_mid_slen,
                           r_mid_plen, r_mid_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign clr_acc  = s_acc && (in_kind == KIND_CLEAR);
    assign end_acc  = s_acc && (in_kind == KIND_PAYLOAD) && in_last;
    assign clr_done = (r_total == '0) && (r_crc == CRC_INIT) && (r_pos == '0);

    `PFR_ASSERT_NOW(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= LEN_W'(STORE_DEPTH))
    `PFR_ASSERT_NEXT(a_clear_state, i_clk, i_rst_n, clr_acc, clr_done)
    `PFR_ASSERT_NEXT(a_frame_end_pos, i_clk, i_rst_n, end_acc, r_pos == '0 && r_mid_valid)
    `PFR_ASSERT_NEXT(a_mid_to_out, i_clk, i_rst_n, adv && r_mid_valid, r_out_valid)

endmodule

// File: verif/tb_packet_frame_reassembler_crc.sv
// ----------------------------------------------------------------------------
// Testbench for the packet frame reassembler
// Streams payload, clear and read items into the block and checks every
// status report against an in-bench model of the reassembly, the store and
// the lagged CRC-16. The stimulus runs through several capacity settings and
// mixes well-formed packets with correct CRCs, reads, and broken frames.
// ----------------------------------------------------------------------------
module tb_packet_frame_reassembler_crc;
    import pfr_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SETTLE      = 8;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    // two copies of the model: one follows accepted transfers, one plans stimulus
    localparam int          TRACK_BUS   = 0;
    localparam int          TRACK_PLAN  = 1;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] ridx;
        logic       eof;
        logic [4:0] cnt;
        logic [7:0] data;
        logic       last;
    } item_t;

    // same layout as o_m_tdata, lowest field last
    typedef struct packed {
        logic [7:0]  rdata;
        logic [10:0] slen;
        logic [9:0]  plen;
        logic [2:0]  status;
    } report_t;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata   = '0;  // data_byte, frame_counter, frame_eof, read_index
    logic [1:0]  i_s_tuser   = '0;  // kind
    logic        i_s_tlast   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;         // status, packet_length, stored_length, read_data

    packet_frame_reassembler_crc uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // reassembly state, one copy per track
    logic [7:0]  trk_store [2][STORE_DEPTH];
    logic [10:0] trk_cap [2];
    int          trk_total [2];
    int          trk_plen [2];
    int          trk_pos [2];
    int          trk_take [2];
    logic [7:0]  trk_exp [2];
    logic [15:0] trk_crc [2];
    logic [2:0]  trk_verdict [2];

    item_t   feed_q[$];
    report_t awaited_reports[$];
    int      fill_mark     = 0;
    int      phase_items   = 0;
    int      fail_count    = 0;
    int      cycles        = 0;
    int      gap_left      = 0;
    int      stall_left    = 0;
    int      hold_left     = 0;
    int      hold_requests = 0;
    int      holds_done    = 0;
    bit      no_idle       = 1'b0;
    bit      s_took        = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ d[i];
            acc = {acc[14:0], 1'b0};
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void clear_track(input int m);
        trk_total[m]   = 0;
        trk_plen[m]    = 0;
        trk_pos[m]     = 0;
        trk_take[m]    = 0;
        trk_exp[m]     = '0;
        trk_crc[m]     = 16'hFFFF;
        trk_verdict[m] = '0;
    endfunction

    // one item through the reassembly; returns 1 when it yields a report
    function automatic bit reasm_step(input int m, input item_t it, output report_t r);
        int cap;
        int t;
        r   = '0;
        cap = (int'(trk_cap[m]) > STORE_DEPTH) ? STORE_DEPTH : int'(trk_cap[m]);
        case (it.kind)
            KIND_CLEAR: begin
                clear_track(m);
                return 1'b0;
            end
            KIND_READ: begin
                r.status = ST_PROGRESS;
                r.plen   = 10'(trk_plen[m]);
                r.slen   = 11'(trk_total[m]);
                r.rdata  = trk_store[m][it.ridx];
                return 1'b1;
            end
            KIND_PAYLOAD: ;
            default: return 1'b0;
        endcase

        // frame checks run on the first byte only
        if (trk_pos[m] == 0) begin
            trk_take[m] = 0;
            if (cap == 0) begin
                trk_verdict[m] = ST_OVERFLOW;
            end else if (!it.eof) begin
                if ({3'b000, it.cnt} != trk_exp[m]) begin
                    trk_verdict[m] = ST_SEQUENCE;
                end else if (trk_total[m] + FRAME_BYTES > cap) begin
                    trk_verdict[m] = ST_OVERFLOW;
                end else begin
                    trk_verdict[m] = ST_PROGRESS;
                    trk_take[m]    = FRAME_BYTES;
                    trk_exp[m]     = trk_exp[m] + 8'd1;
                end
            end else begin
                if (it.cnt == 5'd0 || int'(it.cnt) > FRAME_BYTES) begin
                    trk_verdict[m] = ST_INVALID;
                end else if (trk_total[m] + int'(it.cnt) > cap) begin
                    trk_verdict[m] = ST_OVERFLOW;
                end else begin
                    trk_verdict[m] = VERDICT_END_OK;
                    trk_take[m]    = int'(it.cnt);
                end
            end
        end

        t = trk_total[m];
        if (trk_pos[m] < trk_take[m] && t < STORE_DEPTH) begin
            // CRC trails the append point by two bytes
            if (t >= 2) begin
                trk_crc[m] = crc_byte(trk_crc[m], trk_store[m][t-2]);
            end
            trk_store[m][t] = it.data;
            trk_total[m]    = t + 1;
        end
        if (trk_pos[m] < 31) begin
            trk_pos[m]++;
        end

        if (!it.last) begin
            return 1'b0;
        end
        trk_pos[m] = 0;
        t = trk_total[m];
        if (trk_verdict[m] != VERDICT_END_OK) begin
            r.status = trk_verdict[m];
        end else if (t < 3) begin
            r.status = ST_CRC;
        end else if ({trk_store[m][t-2], trk_store[m][t-1]} != trk_crc[m]) begin
            r.status = ST_CRC;
        end else begin
            trk_plen[m] = t - 2;
            r.status    = ST_COMPLETE;
        end
        r.plen = 10'(trk_plen[m]);
        r.slen = 11'(t);
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus planning
    // ------------------------------------------------------------------
    function automatic item_t rand_item(input logic [1:0] kind);
        item_t it;
        it.kind = kind;
        it.ridx = 10'($urandom);
        it.eof  = 1'($urandom);
        it.cnt  = 5'($urandom);
        it.data = 8'($urandom);
        it.last = 1'($urandom);
        return it;
    endfunction

    task automatic feed(input item_t it);
        report_t r;
        void'(reasm_step(TRACK_PLAN, it, r));
        if (trk_total[TRACK_PLAN] > fill_mark) begin
            fill_mark = trk_total[TRACK_PLAN];
        end
        feed_q.push_back(it);
        if (it.kind != KIND_UNUSED) begin
            phase_items++;
        end
    endtask

    // good: an end frame whose last two bytes carry the matching CRC
    task automatic push_frame(input bit eof, input logic [4:0] cnt, input int nbytes,
                              input bit good, input bit tag_noise);
        item_t       it;
        logic [15:0] crc;
        int          t;
        crc = '0;
        for (int j = 0; j < nbytes; j++) begin
            it      = rand_item(KIND_PAYLOAD);
            it.last = (j == nbytes - 1);
            if (j == 0 || !tag_noise) begin
                it.cnt = cnt;
                it.eof = eof;
            end
            if (good && eof && int'(cnt) == nbytes && nbytes >= 2) begin
                if (j == nbytes - 2) begin
                    // fold the stored bytes the running CRC has not reached yet
                    crc = trk_crc[TRACK_PLAN];
                    t   = trk_total[TRACK_PLAN];
                    for (int k = (t >= 2) ? t - 2 : 0; k < t; k++) begin
                        crc = crc_byte(crc, trk_store[TRACK_PLAN][k]);
                    end
                    it.data = crc[15:8];
                end else if (j == nbytes - 1) begin
                    it.data = crc[7:0];
                end
            end
            feed(it);
        end
    endtask

    task automatic packet_seq(input bit corrupt);
        int n;
        if ($urandom_range(0, 1) == 1) begin
            feed(rand_item(KIND_CLEAR));
        end
        repeat ($urandom_range(0, 2)) begin
            push_frame(1'b0, trk_exp[TRACK_PLAN][4:0],
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : FRAME_BYTES,
                       1'b0, $urandom_range(0, 3) == 0);
        end
        n = ($urandom_range(0, 1) == 1) ? $urandom_range(2, 6) : $urandom_range(2, FRAME_BYTES);
        push_frame(1'b1, 5'(n), n, !corrupt, $urandom_range(0, 3) == 0);
    endtask

    task automatic read_seq();
        item_t it;
        if (fill_mark > 0) begin
            repeat ($urandom_range(1, 4)) begin
                it      = rand_item(KIND_READ);
                it.ridx = 10'($urandom_range(0, fill_mark - 1));
                feed(it);
            end
        end
    endtask

    task automatic noise_seq();
        item_t it;
        case ($urandom_range(0, 4))
            0: push_frame(1'($urandom), 5'($urandom), $urandom_range(1, 40),
                          1'b0, 1'($urandom));
            1: push_frame(1'b0, trk_exp[TRACK_PLAN][4:0] + 5'($urandom_range(1, 31)),
                          $urandom_range(1, FRAME_BYTES), 1'b0, 1'b0);
            2: begin
                // frame cut short by a clear
                repeat ($urandom_range(1, 6)) begin
                    it      = rand_item(KIND_PAYLOAD);
                    it.last = 1'b0;
                    feed(it);
                end
                feed(rand_item(KIND_CLEAR));
            end
            3: feed(rand_item(KIND_UNUSED));
            default: packet_seq(1'b1);
        endcase
    endtask

    task automatic wait_idle();
        while (feed_q.size() != 0 || i_s_tvalid || awaited_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [10:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        trk_cap[TRACK_BUS]  = value;
        trk_cap[TRACK_PLAN] = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [10:0] cap, input int target);
        wait_idle();
        cfg_write(cap);
        phase_items = 0;
        while (phase_items < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: packet_seq(1'b0);
                5, 6:          read_seq();
                default:       noise_seq();
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial begin
        item_t it;
        clear_track(TRACK_BUS);
        clear_track(TRACK_PLAN);
        trk_cap[TRACK_BUS]  = '0;
        trk_cap[TRACK_PLAN] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // capacity still zero from reset: every frame overflows
        push_frame(1'b0, 5'd0, 3, 1'b0, 1'b0);
        push_frame(1'b1, 5'd2, 2, 1'b1, 1'b0);
        it = '1;
        feed(it);
        feed(rand_item(KIND_CLEAR));

        wait_idle();
        cfg_write(11'd1024);
        push_frame(1'b1, 5'd0, 1, 1'b0, 1'b0);            // zero byte count
        push_frame(1'b1, 5'd31, 2, 1'b0, 1'b0);           // count above frame size
        push_frame(1'b0, 5'd9, 1, 1'b0, 1'b0);            // wrong counter
        push_frame(1'b1, 5'd2, 2, 1'b0, 1'b0);            // too short to hold a CRC
        it      = rand_item(KIND_READ);
        it.ridx = 10'd0;
        feed(it);
        it.ridx = 10'd1;
        feed(it);
        feed(rand_item(KIND_CLEAR));
        push_frame(1'b1, 5'd3, 3, 1'b1, 1'b0);            // smallest good packet
        push_frame(1'b0, 5'd0, 4, 1'b0, 1'b1);            // short frame, tags change
        push_frame(1'b1, 5'd4, 4, 1'b1, 1'b0);            // next packet, CRC carries on
        it.ridx = 10'(fill_mark - 1);
        feed(it);

        // a multi-frame packet, then read it back under a long hold
        wait_idle();
        cfg_write(11'd1024);
        feed(rand_item(KIND_CLEAR));
        repeat (6) push_frame(1'b0, trk_exp[TRACK_PLAN][4:0], FRAME_BYTES, 1'b0, 1'b0);
        push_frame(1'b1, 5'd10, 10, 1'b1, 1'b0);
        wait_idle();
        hold_requests++;
        for (int j = 0; j < 40; j++) begin
            it      = rand_item(KIND_READ);
            it.ridx = 10'($urandom_range(0, fill_mark - 1));
            feed(it);
        end

        run_phase(11'd1024, 30);
        run_phase(11'd1, 35);
        run_phase(11'd60, 35);
        run_phase(11'd2047, 35);
        run_phase(11'd0, 25);
        run_phase(11'($urandom_range(100, 1000)), 35);
        wait_idle();
        no_idle = 1'b1;
        run_phase(11'd1024, 40);
        wait_idle();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        item_t nxt;
        bit    offer;
        if (i_rst_n && (!i_s_tvalid || s_took)) begin
            offer = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (feed_q.size() > 0) begin
                if (!no_idle && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 16);
                end else begin
                    nxt       = feed_q.pop_front();
                    offer     = 1'b1;
                    i_s_tdata <= {nxt.ridx, nxt.eof, nxt.cnt, nxt.data};
                    i_s_tuser <= nxt.kind;
                    i_s_tlast <= nxt.last;
                end
            end
            i_s_tvalid <= offer;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        bit rdy;
        rdy = 1'b1;
        if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            rdy        = 1'b0;
        end
        i_m_tready <= rdy;
    end

    // ------------------------------------------------------------------
    // monitor: model follows accepted input transfers, reports are checked in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        report_t got;
        report_t want;
        report_t r;
        item_t   seen;
        if (!i_rst_n) begin
            s_took <= 1'b0;
        end else begin
            s_took <= i_s_tvalid && o_s_tready;
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata;
                if (awaited_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, o_m_tdata);
                    fail_count++;
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("status", int'(want.status), int'(got.status));
                    check_field("packet_length", int'(want.plen), int'(got.plen));
                    check_field("stored_length", int'(want.slen), int'(got.slen));
                    check_field("read_data", int'(want.rdata), int'(got.rdata));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                seen.kind = i_s_tuser;
                seen.data = i_s_tdata[7:0];
                seen.cnt  = i_s_tdata[12:8];
                seen.eof  = i_s_tdata[13];
                seen.ridx = i_s_tdata[23:14];
                seen.last = i_s_tlast;
                if (reasm_step(TRACK_BUS, seen, r)) begin
                    awaited_reports.push_back(r);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

// File: packet_frame_reassembler_crc.f
+incdir+rtl
rtl/pfr_pkg.sv
rtl/pfr_ram.sv
rtl/packet_frame_reassembler_crc.sv
verif/tb_packet_frame_reassembler_crc.sv
